FILE: design/planar_body_euler_step_with_cost_macros.svh
// assertion macros for the planar body euler step block
`ifndef PLANAR_BODY_EULER_STEP_WITH_COST_MACROS_SVH
`define PLANAR_BODY_EULER_STEP_WITH_COST_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PECS_ASSERT_IMP(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error("pecs assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define PECS_ASSERT_NXT(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error("pecs assertion failed");

`endif

FILE: design/pecs_pkg.sv
// shared types, constants and saturation helpers for the planar body euler step
package pecs_pkg;

	localparam int WORD_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int COST_W    = 64;
	localparam int DT_W      = 31;
	localparam int TRIG_W    = FRAC_BITS + 2;
	localparam int IDX_W     = 3;

	localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1) <<< FRAC_BITS;

	// 1/(2*pi) in q32
	localparam logic signed [31:0] INV_TWO_PI_Q32 = 32'sd683565276;
	// q30 taylor coefficients of sin(pi/2*z)
	localparam logic [30:0] SC1 = 31'd1686629713;
	localparam logic [30:0] SC3 = 31'd693598668;
	localparam logic [30:0] SC5 = 31'd85569306;
	localparam logic [30:0] SC7 = 31'd5026995;
	localparam logic [30:0] SC9 = 31'd172272;

	typedef enum logic [IDX_W-1:0] {
		REG_TIME_STEP    = 3'd0,
		REG_WEIGHT_CONST = 3'd1,
		REG_WEIGHT_FWD   = 3'd2,
		REG_WEIGHT_LAT   = 3'd3,
		REG_WEIGHT_YAW   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic        [DT_W-1:0]   time_step;
		logic signed [WORD_W-1:0] weight_const;
		logic signed [WORD_W-1:0] weight_fwd;
		logic signed [WORD_W-1:0] weight_lat;
		logic signed [WORD_W-1:0] weight_yaw;
	} cfg_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] pos_x;
		logic signed [WORD_W-1:0] pos_y;
		logic signed [WORD_W-1:0] heading;
		logic signed [WORD_W-1:0] vel_fwd;
		logic signed [WORD_W-1:0] vel_lat;
		logic signed [WORD_W-1:0] vel_yaw;
		logic signed [WORD_W-1:0] acc_fwd;
		logic signed [WORD_W-1:0] acc_lat;
		logic signed [WORD_W-1:0] acc_yaw;
	} in_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] next_pos_x;
		logic signed [WORD_W-1:0] next_pos_y;
		logic signed [WORD_W-1:0] next_heading;
		logic signed [WORD_W-1:0] next_vel_fwd;
		logic signed [WORD_W-1:0] next_vel_lat;
		logic signed [WORD_W-1:0] next_vel_yaw;
		logic signed [COST_W-1:0] step_cost;
		logic signed [WORD_W-1:0] cos_dt;
		logic signed [WORD_W-1:0] sin_dt;
		logic signed [WORD_W-1:0] grad_fwd;
		logic signed [WORD_W-1:0] grad_lat;
		logic signed [WORD_W-1:0] grad_yaw;
	} out_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] next_heading;
		logic signed [WORD_W-1:0] next_vel_fwd;
		logic signed [WORD_W-1:0] next_vel_lat;
		logic signed [WORD_W-1:0] next_vel_yaw;
		logic signed [COST_W-1:0] step_cost;
		logic signed [WORD_W-1:0] grad_fwd;
		logic signed [WORD_W-1:0] grad_lat;
		logic signed [WORD_W-1:0] grad_yaw;
	} lanes_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] pos_x;
		logic signed [WORD_W-1:0] pos_y;
		logic signed [WORD_W-1:0] vel_fwd;
		logic signed [WORD_W-1:0] vel_lat;
	} pv_t;

	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [65:0] v);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = (66'sd1 <<< (WORD_W - 1)) - 66'sd1;
		lo = -hi - 66'sd1;
		if (v > hi)
			return hi[WORD_W-1:0];
		else if (v < lo)
			return lo[WORD_W-1:0];
		else
			return v[WORD_W-1:0];
	endfunction

	function automatic logic signed [COST_W-1:0] sat_cost(input logic signed [65:0] v);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = (66'sd1 <<< (COST_W - 1)) - 66'sd1;
		lo = -hi - 66'sd1;
		if (v > hi)
			return hi[COST_W-1:0];
		else if (v < lo)
			return lo[COST_W-1:0];
		else
			return v[COST_W-1:0];
	endfunction

endpackage

FILE: design/pecs_sincos.sv
// pipelined quadrant sine and cosine of the heading, eight stages
module pecs_sincos import pecs_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [WORD_W-1:0] heading,
	output logic signed [TRIG_W-1:0] cos_val,
	output logic signed [TRIG_W-1:0] sin_val
);

	// lane 0 is sine, lane 1 is cosine
	logic signed [63:0]       ph_prod_s1;
	logic        [31:0]       ph      [2];
	logic        [30:0]       z_c     [2];
	logic        [30:0]       z_s2    [2];
	logic        [30:0]       z_s3    [2];
	logic        [30:0]       z_s4    [2];
	logic        [30:0]       z_s5    [2];
	logic        [30:0]       z_s6    [2];
	logic                     neg_s2  [2];
	logic                     neg_s3  [2];
	logic                     neg_s4  [2];
	logic                     neg_s5  [2];
	logic                     neg_s6  [2];
	logic                     neg_s7  [2];
	logic        [61:0]       zz_s2   [2];
	logic        [30:0]       z2_c    [2];
	logic        [30:0]       z2_s3   [2];
	logic        [30:0]       z2_s4   [2];
	logic        [30:0]       z2_s5   [2];
	logic        [30:0]       p7_c    [2];
	logic        [30:0]       p7_s3   [2];
	logic        [30:0]       p5_s4   [2];
	logic        [30:0]       p3_s5   [2];
	logic        [30:0]       p1_s6   [2];
	logic        [30:0]       pz_s7   [2];
	logic        [30:0]       rnd_c   [2];
	logic        [FRAC_BITS:0] mag_c  [2];
	logic signed [TRIG_W-1:0] trig_s8 [2];

	always_comb begin
		ph[0] = ph_prod_s1[FRAC_BITS+31:FRAC_BITS];
		ph[1] = ph[0] + 32'h4000_0000;
		for (int k = 0; k < 2; k++) begin
			z_c[k]  = ph[k][30] ? (31'h4000_0000 - {1'b0, ph[k][29:0]}) : {1'b0, ph[k][29:0]};
			z2_c[k] = zz_s2[k][60:30];
			p7_c[k] = SC7 - 31'((62'(SC9) * 62'(z2_c[k])) >> 30);
			rnd_c[k] = pz_s7[k] + (31'd1 << (29 - FRAC_BITS));
			mag_c[k] = rnd_c[k][30-FRAC_BITS+:FRAC_BITS+1];
			if (mag_c[k] > (FRAC_BITS+1)'(1 << FRAC_BITS))
				mag_c[k] = (FRAC_BITS+1)'(1 << FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_prod_s1 <= 64'(heading) * 64'(INV_TWO_PI_Q32);
			for (int k = 0; k < 2; k++) begin
				z_s2[k]   <= z_c[k];
				neg_s2[k] <= ph[k][31];
				zz_s2[k]  <= 62'(z_c[k]) * 62'(z_c[k]);

				z_s3[k]   <= z_s2[k];
				neg_s3[k] <= neg_s2[k];
				z2_s3[k]  <= z2_c[k];
				p7_s3[k]  <= p7_c[k];

				z_s4[k]   <= z_s3[k];
				neg_s4[k] <= neg_s3[k];
				z2_s4[k]  <= z2_s3[k];
				p5_s4[k]  <= SC5 - 31'((62'(p7_s3[k]) * 62'(z2_s3[k])) >> 30);

				z_s5[k]   <= z_s4[k];
				neg_s5[k] <= neg_s4[k];
				z2_s5[k]  <= z2_s4[k];
				p3_s5[k]  <= SC3 - 31'((62'(p5_s4[k]) * 62'(z2_s4[k])) >> 30);

				z_s6[k]   <= z_s5[k];
				neg_s6[k] <= neg_s5[k];
				p1_s6[k]  <= SC1 - 31'((62'(p3_s5[k]) * 62'(z2_s5[k])) >> 30);

				neg_s7[k] <= neg_s6[k];
				pz_s7[k]  <= 31'((62'(p1_s6[k]) * 62'(z_s6[k])) >> 30);

				trig_s8[k] <= neg_s7[k] ? -$signed({1'b0, mag_c[k]}) : $signed({1'b0, mag_c[k]});
			end
		end
	end

	assign sin_val = trig_s8[0];
	assign cos_val = trig_s8[1];

endmodule

FILE: design/pecs_lanes.sv
// three-stage lanes for heading and velocity integration, control cost and gradient
module pecs_lanes import pecs_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  in_t    item,
	input  cfg_t   cfg,
	output lanes_t result
);

	logic signed [WORD_W-1:0] dt_s;
	logic signed [WORD_W-1:0] base_c  [4];
	logic signed [WORD_W-1:0] rate_c  [4];
	logic signed [WORD_W-1:0] ctl_c   [3];
	logic signed [WORD_W-1:0] wgt_c   [3];
	logic signed [WORD_W-1:0] hi_c    [3];
	logic        [FRAC_BITS-1:0] lo_c [3];
	logic signed [WORD_W-1:0] base_s1 [4];
	logic signed [63:0]       dtp_s1  [4];
	logic signed [63:0]       uu_s1   [3];
	logic signed [63:0]       wu_s1   [3];
	logic signed [WORD_W-1:0] nxt_s2  [4];
	logic signed [WORD_W-1:0] grad_s2 [3];
	logic signed [63:0]       whi_s2  [3];
	logic signed [63:0]       wlo_s2  [3];
	logic signed [65:0]       sum_c;
	lanes_t                   result_s3;

	always_comb begin
		dt_s = $signed({1'b0, cfg.time_step});
		base_c[0] = item.heading;
		base_c[1] = item.vel_fwd;
		base_c[2] = item.vel_lat;
		base_c[3] = item.vel_yaw;
		rate_c[0] = item.vel_yaw;
		rate_c[1] = item.acc_fwd;
		rate_c[2] = item.acc_lat;
		rate_c[3] = item.acc_yaw;
		ctl_c[0]  = item.acc_fwd;
		ctl_c[1]  = item.acc_lat;
		ctl_c[2]  = item.acc_yaw;
		wgt_c[0]  = cfg.weight_fwd;
		wgt_c[1]  = cfg.weight_lat;
		wgt_c[2]  = cfg.weight_yaw;
		for (int k = 0; k < 3; k++) begin
			// square split into integer and fraction parts
			hi_c[k] = WORD_W'(uu_s1[k] >>> (2 * FRAC_BITS));
			lo_c[k] = uu_s1[k][2*FRAC_BITS-1:FRAC_BITS];
		end
		sum_c = 66'(cfg.weight_const);
		for (int k = 0; k < 3; k++)
			sum_c = sum_c + 66'(whi_s2[k]) + 66'(wlo_s2[k] >>> FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				base_s1[k] <= base_c[k];
				dtp_s1[k]  <= 64'(rate_c[k]) * 64'(dt_s);
				nxt_s2[k]  <= sat_word(66'(base_s1[k]) + 66'(dtp_s1[k] >>> FRAC_BITS));
			end
			for (int k = 0; k < 3; k++) begin
				uu_s1[k]   <= 64'(ctl_c[k]) * 64'(ctl_c[k]);
				wu_s1[k]   <= 64'(wgt_c[k]) * 64'(ctl_c[k]);
				grad_s2[k] <= sat_word(66'(wu_s1[k] >>> (FRAC_BITS - 1)));
				whi_s2[k]  <= 64'(wgt_c[k]) * 64'(hi_c[k]);
				wlo_s2[k]  <= 64'(wgt_c[k]) * 64'($signed({1'b0, lo_c[k]}));
			end
			result_s3.next_heading <= nxt_s2[0];
			result_s3.next_vel_fwd <= nxt_s2[1];
			result_s3.next_vel_lat <= nxt_s2[2];
			result_s3.next_vel_yaw <= nxt_s2[3];
			result_s3.grad_fwd     <= grad_s2[0];
			result_s3.grad_lat     <= grad_s2[1];
			result_s3.grad_yaw     <= grad_s2[2];
			result_s3.step_cost    <= sat_cost(sum_c);
		end
	end

	assign result = result_s3;

endmodule

FILE: design/planar_body_euler_step_with_cost.sv
// top level of the planar body euler step with control cost
//
// item channel: item_valid, item_stall and one in_t state and control per transfer.
// result channel: result_valid, result_stall and one out_t per transfer, in order.
// cfg channel: cfg_valid, cfg_ready (always high), cfg_index and cfg_data; indexes
// beyond the register list are ignored. write only while the pipeline is empty.
// the pipeline accepts one item per cycle while result_stall does not hold it.
// the chain is the heading phase multiply, a four-step horner polynomial for the
// sine and cosine, the dt scaling, the rotation multiplies and the final add.
// cost, gradient and velocity lanes finish in three stages and ride alongside.
// while result_valid and result_stall are both high the whole pipeline holds and
// item_stall is high, so nothing is lost or repeated.
// reset clears the valid bits and loads the default registers: dt about 0.1,
// weight_const 1.0, weight_fwd 1.2, weight_lat 1.7, weight_yaw 0.7.
module planar_body_euler_step_with_cost import pecs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  in_t              item,
	output logic             result_valid,
	input  logic             result_stall,
	output out_t             result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [31:0]      cfg_data
);

	`include "planar_body_euler_step_with_cost_macros.svh"

	localparam int PIPE_DEPTH = 11;
	localparam int PV_DEPTH   = 10;
	localparam int LN_DEPTH   = 7;

	cfg_t                     cfg_q;
	logic [PIPE_DEPTH-1:0]    vld_q;
	logic                     en;
	logic signed [WORD_W-1:0] dt_s;
	logic signed [TRIG_W-1:0] cs_cos;
	logic signed [TRIG_W-1:0] cs_sin;
	lanes_t                   lanes;
	pv_t                      pv_q [PV_DEPTH];
	lanes_t                   ln_q [LN_DEPTH];
	logic signed [WORD_W-1:0] cdt_s9;
	logic signed [WORD_W-1:0] sdt_s9;
	logic signed [WORD_W-1:0] cdt_s10;
	logic signed [WORD_W-1:0] sdt_s10;
	logic signed [63:0]       cvf_s10;
	logic signed [63:0]       svl_s10;
	logic signed [63:0]       cvl_s10;
	logic signed [63:0]       svf_s10;
	out_t                     result_q;

	assign en           = !(vld_q[PIPE_DEPTH-1] && result_stall);
	assign item_stall   = !en;
	assign result_valid = vld_q[PIPE_DEPTH-1];
	assign result       = result_q;
	assign cfg_ready    = 1'b1;
	assign dt_s         = $signed({1'b0, cfg_q.time_step});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_step    <= DT_W'(6554);
			cfg_q.weight_const <= WORD_W'(65536);
			cfg_q.weight_fwd   <= WORD_W'(78643);
			cfg_q.weight_lat   <= WORD_W'(111411);
			cfg_q.weight_yaw   <= WORD_W'(45875);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TIME_STEP:    cfg_q.time_step    <= cfg_data[DT_W-1:0];
				REG_WEIGHT_CONST: cfg_q.weight_const <= cfg_data;
				REG_WEIGHT_FWD:   cfg_q.weight_fwd   <= cfg_data;
				REG_WEIGHT_LAT:   cfg_q.weight_lat   <= cfg_data;
				REG_WEIGHT_YAW:   cfg_q.weight_yaw   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], item_valid};
		end
	end

	pecs_sincos u_sincos (
		.clk     (clk),
		.en      (en),
		.heading (item.heading),
		.cos_val (cs_cos),
		.sin_val (cs_sin)
	);

	pecs_lanes u_lanes (
		.clk    (clk),
		.en     (en),
		.item   (item),
		.cfg    (cfg_q),
		.result (lanes)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			pv_q[0].pos_x   <= item.pos_x;
			pv_q[0].pos_y   <= item.pos_y;
			pv_q[0].vel_fwd <= item.vel_fwd;
			pv_q[0].vel_lat <= item.vel_lat;
			for (int k = 1; k < PV_DEPTH; k++)
				pv_q[k] <= pv_q[k-1];
			ln_q[0] <= lanes;
			for (int k = 1; k < LN_DEPTH; k++)
				ln_q[k] <= ln_q[k-1];

			cdt_s9 <= sat_word(66'((64'(cs_cos) * 64'(dt_s)) >>> FRAC_BITS));
			sdt_s9 <= sat_word(66'((64'(cs_sin) * 64'(dt_s)) >>> FRAC_BITS));

			cdt_s10 <= cdt_s9;
			sdt_s10 <= sdt_s9;
			cvf_s10 <= 64'(cdt_s9) * 64'(pv_q[PV_DEPTH-2].vel_fwd);
			svl_s10 <= 64'(sdt_s9) * 64'(pv_q[PV_DEPTH-2].vel_lat);
			cvl_s10 <= 64'(cdt_s9) * 64'(pv_q[PV_DEPTH-2].vel_lat);
			svf_s10 <= 64'(sdt_s9) * 64'(pv_q[PV_DEPTH-2].vel_fwd);

			result_q.next_pos_x <= sat_word(66'(pv_q[PV_DEPTH-1].pos_x)
				+ ((66'(cvf_s10) - 66'(svl_s10)) >>> FRAC_BITS));
			result_q.next_pos_y <= sat_word(66'(pv_q[PV_DEPTH-1].pos_y)
				+ ((66'(cvl_s10) + 66'(svf_s10)) >>> FRAC_BITS));
			result_q.next_heading <= ln_q[LN_DEPTH-1].next_heading;
			result_q.next_vel_fwd <= ln_q[LN_DEPTH-1].next_vel_fwd;
			result_q.next_vel_lat <= ln_q[LN_DEPTH-1].next_vel_lat;
			result_q.next_vel_yaw <= ln_q[LN_DEPTH-1].next_vel_yaw;
			result_q.step_cost    <= ln_q[LN_DEPTH-1].step_cost;
			result_q.cos_dt       <= cdt_s10;
			result_q.sin_dt       <= sdt_s10;
			result_q.grad_fwd     <= ln_q[LN_DEPTH-1].grad_fwd;
			result_q.grad_lat     <= ln_q[LN_DEPTH-1].grad_lat;
			result_q.grad_yaw     <= ln_q[LN_DEPTH-1].grad_yaw;
		end
	end

	// output empties when nothing follows and the receiver takes the transfer
	`PECS_ASSERT_NXT(a_drain, result_valid && !result_stall && !vld_q[PIPE_DEPTH-2], !result_valid)
	// a stalled receiver freezes every stage
	`PECS_ASSERT_NXT(a_freeze, result_valid && result_stall, result_valid && $stable(vld_q))
	// unit circle bound on the trig stage
	`PECS_ASSERT_IMP(a_trig_range, vld_q[7], (cs_cos <= TRIG_ONE) && (cs_cos >= -TRIG_ONE) && (cs_sin <= TRIG_ONE) && (cs_sin >= -TRIG_ONE))

endmodule
